/* rtl/uniform_grid_quantizer_unit_macros.svh */
// Assertion macros shared by the uniform grid quantizer RTL.
`ifndef UNIFORM_GRID_QUANTIZER_UNIT_MACROS_SVH
`define UNIFORM_GRID_QUANTIZER_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UGQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ugq assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define UGQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ugq assertion failed");

`endif

/* rtl/ugq_pkg.sv */
// Types and constants shared by the uniform grid quantizer modules.
package ugq_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_OBSERVE    = 2'd1,
        OP_QUANTIZE   = 2'd2,
        OP_DEQUANTIZE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [6:0]         dim;
        logic signed [15:0] sample;
        logic [15:0]        code;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        landmark_index;
        logic signed [15:0] approx_value;
        logic               range_known;
    } t_res;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } t_md_ctrl;

    localparam int                 STEP_W      = 4;
    localparam logic [STEP_W-1:0]  STEP_LAST   = 4'd15;
    localparam logic signed [15:0] RANGE_MIN_RESET = 16'sh7FFF;
    localparam logic signed [15:0] RANGE_MAX_RESET = 16'sh8000;
    localparam logic signed [15:0] VALUE_MAX   = 16'sh7FFF;
    localparam logic [15:0]        LCOUNT_RESET = 16'd256;

endpackage

/* rtl/ugq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ugq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ugq_muldiv.sv */
// Bit-serial shift-add multiplier and restoring divider sharing one 32-bit shift register.
module ugq_muldiv import ugq_pkg::*; (
    input  logic        i_clk,
    input  t_md_ctrl    i_ctrl,
    input  logic [15:0] i_mcand,
    input  logic [15:0] i_mplier,
    input  logic [15:0] i_divisor,
    output logic [31:0] o_acc,
    output logic [15:0] o_divisor,
    output logic        o_sat
);

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [15:0] r_mcand;
    logic [15:0] r_div;
    logic [16:0] mul_sum;
    logic [16:0] div_trial;
    logic        div_ge;
    logic [15:0] div_rem;

    always_comb begin
        mul_sum   = {1'b0, r_acc[31:16]} + (r_acc[0] ? {1'b0, r_mcand} : 17'd0);
        div_trial = {r_acc[31:16], r_acc[15]};
        div_ge    = div_trial >= {1'b0, r_div};
        div_rem   = div_ge ? 16'(div_trial - {1'b0, r_div}) : div_trial[15:0];
        priority if (i_ctrl.load) begin
            n_acc = {16'd0, i_mplier};
        end else if (i_ctrl.mul_step) begin
            n_acc = {mul_sum, r_acc[15:1]};
        end else if (i_ctrl.div_step) begin
            n_acc = {div_rem, r_acc[14:0], div_ge};
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctrl.load) begin
            r_mcand <= i_mcand;
            r_div   <= i_divisor;
        end
    end

    assign o_acc     = r_acc;
    assign o_divisor = r_div;
    assign o_sat     = r_acc[31:16] >= r_div;

endmodule

/* rtl/uniform_grid_quantizer_unit.sv */
// Top level of the uniform grid quantizer: range memory, sequencer and result register.
// Clear, observe and commands needing no division pass through ST_EXEC before the registered result beat.
// Quantize and dequantize run 16 multiply steps, a saturation check and, unless it overflows, 16 divide steps.
// A new command is taken in the cycle its predecessor's result is shown; the receiver cannot stall.
// After reset every address of the range memory is swept to the reset range with busy high.
// Configuration writes are taken in every cycle, including during that sweep.
`include "uniform_grid_quantizer_unit_macros.svh"

module uniform_grid_quantizer_unit import ugq_pkg::*; #(
    parameter int DIMENSIONS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DIMENSIONS - 1);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_valid, n_valid;
    t_res               r_res, n_res;
    logic [15:0]        r_lcount;
    logic               r_sat, n_sat;
    logic signed [15:0] r_lo, n_lo;
    t_cmd               r_cmd;
    logic [AW-1:0]      r_addr;
    logic               r_dim_ok;

    logic               accept;
    logic [31:0]        dim_wide;
    logic               dim_ok_in;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    t_md_ctrl           md_ctrl;
    logic [15:0]        md_mcand;
    logic [15:0]        md_mplier;
    logic [15:0]        md_divisor;
    logic [31:0]        md_acc;
    logic [15:0]        md_div;
    logic               md_sat;

    logic signed [15:0] lo, hi, x;
    logic signed [16:0] diff_w, span_w;
    logic [15:0]        leff, lm1;
    logic               round_up;
    logic [16:0]        q_round;
    logic signed [17:0] approx_w;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    assign dim_wide  = 32'(i_cmd.dim);
    assign dim_ok_in = dim_wide < 32'(DIMENSIONS);
    assign ram_raddr = dim_wide[AW-1:0];

    ugq_ram #(
        .WIDTH (32),
        .DEPTH (DIMENSIONS)
    ) u_range_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ugq_muldiv u_muldiv (
        .i_clk     (i_clk),
        .i_ctrl    (md_ctrl),
        .i_mcand   (md_mcand),
        .i_mplier  (md_mplier),
        .i_divisor (md_divisor),
        .o_acc     (md_acc),
        .o_divisor (md_div),
        .o_sat     (md_sat)
    );

    always_comb begin
        lo       = ram_rdata[31:16];
        hi       = ram_rdata[15:0];
        x        = r_cmd.sample;
        diff_w   = {x[15], x} - {lo[15], lo};
        span_w   = {hi[15], hi} - {lo[15], lo};
        leff     = (r_lcount == 16'd0) ? 16'd1 : r_lcount;
        lm1      = leff - 16'd1;
        round_up = {md_acc[31:16], 1'b0} > {1'b0, md_div};
        q_round  = {1'b0, md_acc[15:0]} + 17'(round_up);
        approx_w = {{2{r_lo[15]}}, r_lo} + {2'b00, md_acc[15:0]};
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_clr_addr = r_clr_addr;
        n_valid    = 1'b0;
        n_res      = r_res;
        n_sat      = r_sat;
        n_lo       = r_lo;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = {RANGE_MIN_RESET, RANGE_MAX_RESET};
        md_ctrl    = '0;
        md_mcand   = 16'd0;
        md_mplier  = 16'd0;
        md_divisor = 16'd0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_res   = '0;
                if (r_dim_ok) begin
                    unique case (r_cmd.op)
                        OP_CLEAR: begin
                            ram_we = 1'b1;
                        end
                        OP_OBSERVE: begin
                            ram_we            = 1'b1;
                            ram_wdata         = {(x < lo) ? x : lo, (x > hi) ? x : hi};
                            n_res.range_known = 1'b1;
                        end
                        OP_QUANTIZE: begin
                            n_res.range_known = (lo <= hi);
                            if ((hi > lo) && (x > lo)) begin
                                n_valid      = 1'b0;
                                n_state      = ST_MUL;
                                n_cnt        = '0;
                                md_ctrl.load = 1'b1;
                                md_mcand     = diff_w[15:0];
                                md_mplier    = leff;
                                md_divisor   = span_w[15:0];
                            end
                        end
                        OP_DEQUANTIZE: begin
                            if (hi >= lo) begin
                                n_valid      = 1'b0;
                                n_state      = ST_MUL;
                                n_cnt        = '0;
                                n_lo         = lo;
                                md_ctrl.load = 1'b1;
                                md_mcand     = span_w[15:0];
                                md_mplier    = r_cmd.code;
                                md_divisor   = leff;
                            end
                        end
                    endcase
                end
            end
            ST_MUL: begin
                md_ctrl.mul_step = 1'b1;
                n_cnt            = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_LAST) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_sat   = md_sat;
                n_cnt   = '0;
                n_state = md_sat ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                md_ctrl.div_step = 1'b1;
                n_cnt            = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state           = ST_IDLE;
                n_valid           = 1'b1;
                n_res             = '0;
                n_res.range_known = 1'b1;
                if (r_cmd.op == OP_QUANTIZE) begin
                    if (r_sat || (q_round > {1'b0, lm1})) begin
                        n_res.landmark_index = lm1;
                    end else begin
                        n_res.landmark_index = q_round[15:0];
                    end
                end else begin
                    if (r_sat || (approx_w > 18'sd32767)) begin
                        n_res.approx_value = VALUE_MAX;
                    end else begin
                        n_res.approx_value = approx_w[15:0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
            r_lcount   <= LCOUNT_RESET;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lcount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sat <= n_sat;
        r_lo  <= n_lo;
        if (accept) begin
            r_cmd    <= i_cmd;
            r_addr   <= ram_raddr;
            r_dim_ok <= dim_ok_in;
        end
    end

    `UGQ_ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, accept, busy && !o_valid)
    `UGQ_ASSERT_SAME(a_unknown_range_zero, i_clk, i_rst_n, o_valid && !o_res.range_known,
        (o_res.landmark_index == 16'd0) && (o_res.approx_value == 16'sd0))
    `UGQ_ASSERT_SAME(a_result_after_work, i_clk, i_rst_n, o_valid, $past(busy))
    `UGQ_ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !ram_we)

endmodule
